// File: hdl/hbe_pkg.sv
// Shared types and constants for the hash binning engine.
`timescale 1ns / 1ps
package hbe_pkg;

  // Widest bin index and slot carried between front and back
  localparam int BIN_FW  = 20;
  localparam int SLOT_FW = 6;

  // Configuration register indexes
  localparam logic [2:0] REG_SEED  = 3'd0;
  localparam logic [2:0] REG_C3    = 3'd1;
  localparam logic [2:0] REG_C2    = 3'd2;
  localparam logic [2:0] REG_C1    = 3'd3;
  localparam logic [2:0] REG_C0    = 3'd4;
  localparam logic [2:0] REG_PRIME = 3'd5;
  localparam logic [2:0] REG_FINAL = 3'd6;
  localparam logic [2:0] REG_RBITS = 3'd7;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_RANGE  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Classified transaction passed from front to back
  typedef struct packed {
    op_t                op;
    logic [BIN_FW-1:0]  bin;
    logic [SLOT_FW-1:0] slot;
    logic [31:0]        data;
  } item_t;

  // Result transaction
  typedef struct packed {
    logic [9:0]  bin;
    logic [2:0]  slot;
    logic [31:0] data;
    logic        valid;
    status_t     status;
    logic [3:0]  peak;
  } res_t;

endpackage

// File: hdl/hbe_front.sv
// Front end: configuration registers, classification and the iterative hash unit.
`timescale 1ns / 1ps
module hbe_front #(
  parameter int NUM_BINS = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_wdata,
  input  logic          in_accept,
  input  logic          in_action,
  input  logic [31:0]   in_element,
  input  logic [9:0]    in_bin_select,
  input  logic [2:0]    in_slot_select,
  output logic          busy,
  output logic          q_push,
  output hbe_pkg::item_t q_item,
  input  logic          q_full
);
  import hbe_pkg::*;

  localparam bit BINS_POW2 = ((NUM_BINS & (NUM_BINS - 1)) == 0);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_DIV  = 5'b00100,
    F_NEXT = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  typedef enum logic [1:0] {
    HS_FIRST  = 2'd0,
    HS_SECOND = 2'd1,
    HS_BIN    = 2'd2
  } hstage_t;

  logic [31:0] seed_r;
  logic [63:0] c3_r, c2_r, c1_r, c0_r, prime_r, final_r;
  logic [4:0]  rbits_r;

  fstate_t     state_r, state_nxt;
  hstage_t     stage_r, stage_nxt;
  logic [31:0] data_r, data_nxt;
  logic [31:0] hi_r, hi_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt, prod_r, prod_nxt;
  logic        pshift_r, pshift_nxt;
  logic [1:0]  mcnt_r, mcnt_nxt;
  logic [63:0] rem_r, rem_nxt, dvd_r, dvd_nxt, mod_r, mod_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  item_t       item_r, item_nxt;

  logic [31:0] mul_x, mul_y, lo_part, hi_part, val_in;
  logic [63:0] mul_p, acc_sum, mix_v;
  logic [64:0] dsh;
  logic        dge;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= '0;
      c3_r    <= '0;
      c2_r    <= '0;
      c1_r    <= '0;
      c0_r    <= '0;
      prime_r <= 64'd1;
      final_r <= 64'd1;
      rbits_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED:  seed_r  <= cfg_wdata[31:0];
        REG_C3:    c3_r    <= cfg_wdata;
        REG_C2:    c2_r    <= cfg_wdata;
        REG_C1:    c1_r    <= cfg_wdata;
        REG_C0:    c0_r    <= cfg_wdata;
        REG_PRIME: prime_r <= cfg_wdata;
        REG_FINAL: final_r <= cfg_wdata;
        REG_RBITS: rbits_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Split the element for permutation mode
  assign hi_part = in_element >> rbits_r;
  assign lo_part = in_element & ((32'h1 << rbits_r) - 32'h1);
  assign val_in  = (rbits_r == 5'd0) ? in_element : lo_part;

  // One 32x32 partial product per cycle
  always_comb begin
    case (mcnt_r)
      2'd0:    begin mul_x = a_r[31:0];  mul_y = b_r[31:0];  end
      2'd1:    begin mul_x = a_r[63:32]; mul_y = b_r[31:0];  end
      2'd2:    begin mul_x = a_r[31:0];  mul_y = b_r[63:32]; end
      default: begin mul_x = '0;         mul_y = '0;         end
    endcase
  end
  assign mul_p   = {32'b0, mul_x} * {32'b0, mul_y};
  assign acc_sum = acc_r + (pshift_r ? {prod_r[31:0], 32'b0} : prod_r);

  // Restoring remainder step, one bit a cycle
  assign dsh     = {rem_r, dvd_r[63]};
  assign dge     = dsh >= {1'b0, mod_r};
  assign mix_v   = {32'b0, hi_r} ^ rem_r;

  always_comb begin
    state_nxt  = state_r;
    stage_nxt  = stage_r;
    data_nxt   = data_r;
    hi_nxt     = hi_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    acc_nxt    = acc_r;
    prod_nxt   = prod_r;
    pshift_nxt = pshift_r;
    mcnt_nxt   = mcnt_r;
    rem_nxt    = rem_r;
    dvd_nxt    = dvd_r;
    mod_nxt    = mod_r;
    dcnt_nxt   = dcnt_r;
    item_nxt   = item_r;
    q_push     = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (in_accept) begin
          if (in_action) begin
            item_nxt.op   = OP_READ;
            item_nxt.bin  = BIN_FW'(in_bin_select);
            item_nxt.slot = SLOT_FW'(in_slot_select);
            item_nxt.data = '0;
            state_nxt     = F_PUSH;
          end else begin
            data_nxt  = val_in;
            hi_nxt    = (rbits_r == 5'd0) ? 32'd0 : hi_part;
            a_nxt     = c3_r;
            b_nxt     = {32'b0, val_in ^ seed_r};
            acc_nxt   = c2_r;
            mcnt_nxt  = '0;
            pshift_nxt = 1'b0;
            stage_nxt = HS_FIRST;
            state_nxt = F_MUL;
          end
        end
      end
      F_MUL: begin
        if (mcnt_r != 2'd3) begin
          prod_nxt   = mul_p;
          pshift_nxt = (mcnt_r != 2'd0);
        end
        if (mcnt_r != 2'd0) begin
          acc_nxt = acc_sum;
        end
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd3) begin
          mod_nxt  = (stage_r == HS_FIRST) ? prime_r : final_r;
          dcnt_nxt = '0;
          if (mod_nxt == 64'd0) begin
            rem_nxt   = acc_sum;
            state_nxt = F_NEXT;
          end else begin
            rem_nxt   = '0;
            dvd_nxt   = acc_sum;
            state_nxt = F_DIV;
          end
        end
      end
      F_DIV: begin
        rem_nxt  = dge ? 64'(dsh - {1'b0, mod_r}) : dsh[63:0];
        dvd_nxt  = {dvd_r[62:0], 1'b0};
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'd63) begin
          state_nxt = F_NEXT;
        end
      end
      F_NEXT: begin
        case (stage_r)
          HS_FIRST: begin
            a_nxt      = rem_r;
            b_nxt      = c1_r;
            acc_nxt    = c0_r;
            mcnt_nxt   = '0;
            pshift_nxt = 1'b0;
            stage_nxt  = HS_SECOND;
            state_nxt  = F_MUL;
          end
          HS_SECOND: begin
            item_nxt.slot = '0;
            item_nxt.data = data_r;
            if (rbits_r == 5'd0) begin
              // Plain mode: flag a hash beyond the bin count
              if (rem_r >= 64'(NUM_BINS)) begin
                item_nxt.op  = OP_RANGE;
                item_nxt.bin = '0;
              end else begin
                item_nxt.op  = OP_INSERT;
                item_nxt.bin = BIN_FW'(rem_r);
              end
              state_nxt = F_PUSH;
            end else if (BINS_POW2) begin
              item_nxt.op  = OP_INSERT;
              item_nxt.bin = BIN_FW'(mix_v & 64'(NUM_BINS - 1));
              state_nxt    = F_PUSH;
            end else begin
              // Reduce the mixed value by the bin count on the divider
              mod_nxt   = 64'(NUM_BINS);
              dvd_nxt   = mix_v;
              rem_nxt   = '0;
              dcnt_nxt  = '0;
              stage_nxt = HS_BIN;
              state_nxt = F_DIV;
            end
          end
          HS_BIN: begin
            item_nxt.op   = OP_INSERT;
            item_nxt.bin  = BIN_FW'(rem_r);
            item_nxt.slot = '0;
            item_nxt.data = data_r;
            state_nxt     = F_PUSH;
          end
          default: state_nxt = F_IDLE;
        endcase
      end
      F_PUSH: begin
        q_push = !q_full;
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      stage_r <= HS_FIRST;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r   <= data_nxt;
    hi_r     <= hi_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    acc_r    <= acc_nxt;
    prod_r   <= prod_nxt;
    pshift_r <= pshift_nxt;
    mcnt_r   <= mcnt_nxt;
    rem_r    <= rem_nxt;
    dvd_r    <= dvd_nxt;
    mod_r    <= mod_nxt;
    dcnt_r   <= dcnt_nxt;
    item_r   <= item_nxt;
  end

  assign busy   = (state_r != F_IDLE);
  assign q_item = item_r;

  a_push_state: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> state_r == F_PUSH)
    else $error("queue push outside push state");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> state_r == F_IDLE)
    else $error("transaction accepted while hashing");
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_MUL && mcnt_r == 2'd3) |=> (state_r == F_DIV || state_r == F_NEXT))
    else $error("multiply did not hand over to reduction");

endmodule

// File: hdl/hbe_queue.sv
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
module hbe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hbe_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output hbe_pkg::item_t dout,
  output logic           empty
);
  import hbe_pkg::*;

  item_t      ent_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wptr_r] <= din;
  end

  assign dout  = ent_r[rptr_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

endmodule

// File: hdl/hbe_back.sv
// Back end: bin store, fill counts, peak load and the result register.
`timescale 1ns / 1ps
module hbe_back #(
  parameter int NUM_BINS     = 1024,
  parameter int BIN_CAPACITY = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hbe_pkg::item_t q_item,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           clearing,
  output hbe_pkg::res_t  out_res,
  output logic           out_empty,
  input  logic           out_pop
);
  import hbe_pkg::*;

  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int ADDR_W = $clog2(NUM_BINS * BIN_CAPACITY);
  localparam int CNT_W  = $clog2(BIN_CAPACITY + 1);

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001,
    B_IDLE  = 5'b00010,
    B_FILL  = 5'b00100,
    B_STORE = 5'b01000,
    B_RESP  = 5'b10000
  } bstate_t;

  logic [31:0]      store_mem [NUM_BINS * BIN_CAPACITY];
  logic [CNT_W-1:0] fill_mem  [NUM_BINS];

  bstate_t          state_r, state_nxt;
  logic [BIN_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0] max_r, max_nxt;
  item_t            cur_r, cur_nxt;
  res_t             res_r, res_nxt;
  res_t             out_r;
  logic             out_vld_r;
  logic [31:0]      st_rd_r;
  logic [CNT_W-1:0] fill_rd_r;

  logic             fill_we, st_we, st_re, load_out;
  logic [BIN_W-1:0] fill_addr, bin_idx;
  logic [CNT_W-1:0] fill_wdata, fill_inc;
  logic [ADDR_W-1:0] st_addr;
  logic             rd_ok;

  assign bin_idx  = BIN_W'(cur_r.bin);
  assign fill_inc = fill_rd_r + CNT_W'(1);
  assign rd_ok    = (32'(cur_r.bin) < 32'(NUM_BINS)) &&
                    (32'(cur_r.slot) < 32'(BIN_CAPACITY)) &&
                    (32'(cur_r.slot) < 32'(fill_rd_r));
  assign st_addr  = ADDR_W'(bin_idx) * ADDR_W'(BIN_CAPACITY) +
                    ((cur_r.op == OP_READ) ? ADDR_W'(cur_r.slot) : ADDR_W'(fill_rd_r));
  assign load_out = (state_r == B_RESP) && (!out_vld_r || out_pop);

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    max_nxt    = max_r;
    cur_nxt    = cur_r;
    res_nxt    = res_r;
    q_pop      = 1'b0;
    fill_we    = 1'b0;
    fill_addr  = BIN_W'(q_item.bin);
    fill_wdata = fill_inc;
    st_we      = 1'b0;
    st_re      = 1'b0;
    case (state_r)
      B_CLEAR: begin
        // Sweep the fill counts to zero after reset
        fill_we    = 1'b1;
        fill_addr  = clr_r;
        fill_wdata = '0;
        clr_nxt    = clr_r + BIN_W'(1);
        if (clr_r == BIN_W'(NUM_BINS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          state_nxt = B_FILL;
        end
      end
      B_FILL: begin
        res_nxt.bin    = cur_r.bin[9:0];
        res_nxt.slot   = '0;
        res_nxt.data   = cur_r.data;
        res_nxt.valid  = 1'b0;
        res_nxt.status = ST_OK;
        state_nxt      = B_RESP;
        case (cur_r.op)
          OP_RANGE: begin
            res_nxt.bin    = '0;
            res_nxt.status = ST_RANGE;
          end
          OP_INSERT: begin
            if (fill_rd_r >= CNT_W'(BIN_CAPACITY)) begin
              // Drop: bin already full
              res_nxt.status = ST_FULL;
            end else begin
              st_we         = 1'b1;
              fill_we       = 1'b1;
              fill_addr     = bin_idx;
              res_nxt.slot  = fill_rd_r[2:0];
              res_nxt.valid = 1'b1;
              if (fill_inc > max_r) max_nxt = fill_inc;
            end
          end
          OP_READ: begin
            res_nxt.slot = cur_r.slot[2:0];
            res_nxt.data = '0;
            if (rd_ok) begin
              st_re     = 1'b1;
              state_nxt = B_STORE;
            end
          end
          default: ;
        endcase
        res_nxt.peak = 4'(max_nxt);
      end
      B_STORE: begin
        res_nxt.data  = st_rd_r;
        res_nxt.valid = 1'b1;
        state_nxt     = B_RESP;
      end
      B_RESP: begin
        if (load_out) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_CLEAR;
      clr_r     <= '0;
      max_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      max_r   <= max_nxt;
      if (load_out)     out_vld_r <= 1'b1;
      else if (out_pop) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    res_r <= res_nxt;
    if (load_out) out_r <= res_r;
  end

  // Fill count memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_addr] <= fill_wdata;
    fill_rd_r <= fill_mem[BIN_W'(q_item.bin)];
  end

  // Bin store: one write, one registered read
  always_ff @(posedge clk) begin
    if (st_we) store_mem[st_addr] <= cur_r.data;
    if (st_re) st_rd_r <= store_mem[st_addr];
  end

  assign clearing  = (state_r == B_CLEAR);
  assign out_res   = out_r;
  assign out_empty = !out_vld_r;

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CLEAR) |-> !q_pop)
    else $error("queue popped during clearing pass");
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_we |-> (32'(fill_wdata) <= 32'(BIN_CAPACITY)))
    else $error("fill count beyond capacity");
  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.valid) |-> out_r.status == ST_OK)
    else $error("valid entry with error status");

endmodule

// File: hdl/hash_binning_engine_top.sv
// Hash binning engine: top level joining front end, queue and back end.
// Inserts run two multiplies and two remainders on the front end; a zero modulus skips its
// remainder, and permutation mode adds a third when NUM_BINS is not a power of two. Reads
// skip the bin store read when the slot is unfilled or out of range. The front end holds one
// transaction at a time on the shared multiply/remainder unit and takes no new one until done.
// Reset is synchronous, active low; a clearing pass over all bins then keeps full high.
`timescale 1ns / 1ps
module hash_binning_engine_top #(
  parameter int NUM_BINS     = 1024,
  parameter int BIN_CAPACITY = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_action,
  input  logic [31:0] in_element,
  input  logic [9:0]  in_bin_select,
  input  logic [2:0]  in_slot_select,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [9:0]  out_bin_index,
  output logic [2:0]  out_slot_index,
  output logic [31:0] out_entry_data,
  output logic        out_entry_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_peak_load
);
  import hbe_pkg::*;

  logic  front_busy, clearing, q_push, q_pop, q_full, q_empty, in_accept;
  item_t q_din, q_dout;
  res_t  res;

  assign in_full   = front_busy || clearing;
  assign in_accept = in_push && !in_full;

  hbe_front #(.NUM_BINS(NUM_BINS)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_accept, .in_action, .in_element, .in_bin_select, .in_slot_select,
    .busy(front_busy), .q_push, .q_item(q_din), .q_full
  );

  hbe_queue u_queue (
    .clk, .rst_n, .push(q_push), .din(q_din), .full(q_full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  hbe_back #(.NUM_BINS(NUM_BINS), .BIN_CAPACITY(BIN_CAPACITY)) u_back (
    .clk, .rst_n, .q_item(q_dout), .q_empty, .q_pop, .clearing,
    .out_res(res), .out_empty, .out_pop(out_pop && !out_empty)
  );

  assign out_bin_index   = res.bin;
  assign out_slot_index  = res.slot;
  assign out_entry_data  = res.data;
  assign out_entry_valid = res.valid;
  assign out_status      = res.status;
  assign out_peak_load   = res.peak;

endmodule

// File: test/hbe_checker.sv
// Transaction monitor, bin predictor and result comparison for the hash binning engine.
`timescale 1ns / 1ps
module hbe_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_push,
  input  logic        in_full,
  input  logic        in_action,
  input  logic [31:0] in_element,
  input  logic [9:0]  in_bin_select,
  input  logic [2:0]  in_slot_select,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [9:0]  out_bin_index,
  input  logic [2:0]  out_slot_index,
  input  logic [31:0] out_entry_data,
  input  logic        out_entry_valid,
  input  logic [1:0]  out_status,
  input  logic [3:0]  out_peak_load,
  output int          errors,
  output int          outstanding
);
  import hbe_pkg::*;

  localparam int BINS     = 1024;
  localparam int CAPACITY = 8;

  // Mirrored configuration
  logic [31:0] seed_m;
  logic [63:0] c3_m, c2_m, c1_m, c0_m, prime_m, final_m;
  logic [4:0]  rbits_m;

  // Mirrored bin state
  logic [31:0] slot_words [BINS*CAPACITY];
  logic [3:0]  fill_count [BINS];
  logic [3:0]  peak_fill;

  res_t pending_results [$];

  function automatic logic [63:0] mod_or_keep(logic [63:0] v, logic [63:0] m);
    return (m == 64'd0) ? v : v % m;
  endfunction

  function automatic logic [63:0] two_stage_digest(logic [31:0] v);
    logic [63:0] x, t, p;
    x = {32'd0, v ^ seed_m};
    p = c3_m * x + c2_m;
    t = mod_or_keep(p, prime_m);
    p = t * c1_m + c0_m;
    return mod_or_keep(p, final_m);
  endfunction

  // Work out the result of one accepted transaction and update the bin state
  function automatic res_t place_or_fetch(logic act, logic [31:0] elem, logic [9:0] bsel,
                                          logic [2:0] ssel);
    res_t r;
    logic [63:0] h, bin;
    logic [31:0] stored, hi, lo;
    logic [3:0] f;
    r = '0;
    if (act) begin
      r.bin = bsel;
      r.slot = ssel;
      r.status = ST_OK;
      if ({1'b0, ssel} < fill_count[bsel]) begin
        r.data = slot_words[bsel*CAPACITY + ssel];
        r.valid = 1'b1;
      end
    end else begin
      if (rbits_m == 5'd0) begin
        bin = two_stage_digest(elem);
        stored = elem;
      end else begin
        hi = elem >> rbits_m;
        lo = elem & ((32'd1 << rbits_m) - 32'd1);
        h = two_stage_digest(lo);
        bin = ({32'd0, hi} ^ h) % BINS;
        stored = lo;
      end
      r.data = stored;
      if (rbits_m == 5'd0 && bin >= BINS) begin
        r.status = ST_RANGE;
      end else begin
        r.bin = bin[9:0];
        f = fill_count[bin[9:0]];
        if (f >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          slot_words[bin[9:0]*CAPACITY + f] = stored;
          fill_count[bin[9:0]] = f + 4'd1;
          if (f + 4'd1 > peak_fill) peak_fill = f + 4'd1;
          r.slot = f[2:0];
          r.valid = 1'b1;
          r.status = ST_OK;
        end
      end
    end
    r.peak = peak_fill;
    return r;
  endfunction

  function automatic int field_diff(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    res_t want;
    int bad;
    if (!rst_n) begin
      seed_m = '0; c3_m = '0; c2_m = '0; c1_m = '0; c0_m = '0;
      prime_m = 64'd1; final_m = 64'd1; rbits_m = '0;
      for (int i = 0; i < BINS; i++) fill_count[i] = '0;
      peak_fill = '0;
      pending_results.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_SEED:  seed_m  = cfg_wdata[31:0];
          REG_C3:    c3_m    = cfg_wdata;
          REG_C2:    c2_m    = cfg_wdata;
          REG_C1:    c1_m    = cfg_wdata;
          REG_C0:    c0_m    = cfg_wdata;
          REG_PRIME: prime_m = cfg_wdata;
          REG_FINAL: final_m = cfg_wdata;
          REG_RBITS: rbits_m = cfg_wdata[4:0];
          default: ;
        endcase
      end
      // Predict each accepted input transaction
      if (in_push && !in_full)
        pending_results.insert(pending_results.size(),
                               place_or_fetch(in_action, in_element, in_bin_select,
                                              in_slot_select));
      // Compare each accepted result transaction with the oldest prediction
      if (out_pop && !out_empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected, actual bin %0h data %0h", $realtime,
                   out_bin_index, out_entry_data);
          errors++;
        end else begin
          want = pending_results.pop_front();
          bad = 0;
          bad += field_diff("bin_index", want.bin, out_bin_index);
          bad += field_diff("slot_index", want.slot, out_slot_index);
          bad += field_diff("entry_data", want.data, out_entry_data);
          bad += field_diff("entry_valid", want.valid, out_entry_valid);
          bad += field_diff("status", want.status, out_status);
          bad += field_diff("peak_load", want.peak, out_peak_load);
          if (bad != 0) errors++;
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// File: test/tb_top.sv
// Stimulus, handshake pacing and verdict for the hash binning engine.
`timescale 1ns / 1ps
module tb_top;
  import hbe_pkg::*;

  localparam int STALL_LIMIT = 30000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  logic        in_push, in_full, in_action;
  logic [31:0] in_element;
  logic [9:0]  in_bin_select;
  logic [2:0]  in_slot_select;
  logic        out_empty, out_pop;
  logic [9:0]  out_bin_index;
  logic [2:0]  out_slot_index;
  logic [31:0] out_entry_data;
  logic        out_entry_valid;
  logic [1:0]  out_status;
  logic [3:0]  out_peak_load;
  int          errors, outstanding;
  int          tx_idle_pct, rx_idle_pct;
  int          quiet_cycles;

  hash_binning_engine_top DUT (.*);

  hbe_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Pace the result side
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Stop the run if nothing moves for too long
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("hash_binning_engine_top: mismatch");
      $finish;
    end
  end

  task automatic send_item(logic act, logic [31:0] elem, logic [9:0] bsel, logic [2:0] ssel);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_action = act;
    in_element = elem;
    in_bin_select = bsel;
    in_slot_select = ssel;
    in_push = 1'b1;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  // Drain all results, then let the engine settle before touching registers
  task automatic settle();
    in_push = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_setting(logic [31:0] seed, logic [63:0] c3, logic [63:0] c2,
                              logic [63:0] c1, logic [63:0] c0, logic [63:0] pm,
                              logic [63:0] fm, logic [4:0] rb);
    settle();
    write_reg(REG_SEED, {$urandom, seed});
    write_reg(REG_C3, c3);
    write_reg(REG_C2, c2);
    write_reg(REG_C1, c1);
    write_reg(REG_C0, c0);
    write_reg(REG_PRIME, pm);
    write_reg(REG_FINAL, fm);
    write_reg(REG_RBITS, {$urandom, 27'd0, rb});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rand_element();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 3)
        send_item(1'b1, $urandom,
                  ($urandom_range(1) != 0) ? 10'($urandom_range(15)) : 10'($urandom),
                  3'($urandom));
      else
        send_item(1'b0, rand_element(), 10'($urandom), 3'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_push = 1'b0; in_action = 1'b0; in_element = '0;
    in_bin_select = '0; in_slot_select = '0;
    tx_idle_pct = 31;
    rx_idle_pct = 60;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset moduli send every plain insert to bin zero, also after it is full
    send_item(1'b0, 32'h0000_0000, 10'h3FF, 3'd7);
    send_item(1'b0, 32'hFFFF_FFFF, 10'h000, 3'd0);
    for (int i = 0; i < 8; i++) send_item(1'b0, 32'h1234_0000 + i, '0, '0);
    // Read back filled and unfilled slots
    send_item(1'b1, 32'hFFFF_FFFF, 10'd0, 3'd0);
    send_item(1'b1, 32'h0, 10'd0, 3'd7);
    send_item(1'b1, 32'h0, 10'h3FF, 3'd7);
    send_item(1'b1, 32'h0, 10'd1, 3'd0);
    // Zero moduli leave the hash unreduced: hash beyond bin count
    load_setting(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 5'd0);
    send_item(1'b0, 32'h0, '0, '0);
    send_item(1'b0, 32'hFFFF_FFFF, '0, '0);
    // Widest and narrowest low part in permutation mode
    load_setting(32'h0, 64'd3, 64'd1, 64'd5, 64'd7, 64'd4099, 64'd1024, 5'd31);
    send_item(1'b0, 32'hFFFF_FFFF, '0, '0);
    send_item(1'b0, 32'h8000_0000, '0, '0);
    load_setting(32'hA5A5_A5A5, 64'd1, 64'd0, 64'd1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF_FFFF, 5'd1);
    send_item(1'b0, 32'hFFFF_FFFF, '0, '0);
    send_item(1'b0, 32'h0000_0001, '0, '0);

    // Random phases over the three pacing profiles and a spread of settings
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 60 : 0;
      rx_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 31 : 0;
      for (int k = 0; k < 6; k++) begin
        case (k)
          0: load_setting($urandom, rand64(), rand64(), rand64(), rand64(), rand64(),
                          64'($urandom_range(1, 8)), 5'd0);
          1: load_setting($urandom, rand64(), rand64(), rand64(), rand64(), 64'd4099,
                          64'd2000, 5'd0);
          2: load_setting($urandom, rand64(), rand64(), rand64(), rand64(), rand64(),
                          rand64(), 5'($urandom_range(1, 31)));
          3: load_setting(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                          64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0,
                          5'd31);
          4: load_setting($urandom, rand64(), rand64(), rand64(), rand64(),
                          64'($urandom_range(1, 1000)), 64'($urandom_range(1, 1024)),
                          5'($urandom_range(1, 12)));
          default: load_setting(32'd0, rand64(), rand64(), rand64(), rand64(),
                                64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 5'd0);
        endcase
        random_items(32);
      end
    end

    settle();
    if (errors == 0 && outstanding == 0) begin
      $display("hash_binning_engine_top: match");
    end else begin
      $display("hash_binning_engine_top: mismatch");
    end
    $finish;
  end

endmodule

// File: hash_binning_engine_top.f
hdl/hbe_pkg.sv
hdl/hbe_front.sv
hdl/hbe_queue.sv
hdl/hbe_back.sv
hdl/hash_binning_engine_top.sv
test/hbe_checker.sv
test/tb_top.sv
